[rtl/tsf_pkg.sv]
// tsf_pkg: shared widths, constants, register codes and structs for the
// target select / follow command block. No dependencies.
`default_nettype none

package tsf_pkg;

	localparam int COORD_W    = 12;
	localparam int CLASS_W    = 8;
	localparam int DIST_W     = 16;
	localparam int THR_W      = 24;
	localparam int GAIN_W     = 16;
	localparam int MAG_W      = 15;
	localparam int CMD_W      = 16;
	localparam int MODE_W     = 2;
	localparam int AREA_W     = 2 * (COORD_W + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int IMAGE_WIDTH  = 640;
	localparam int VALID_MIN_MM = 50;
	localparam int VALID_MAX_MM = 5000;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_CLASS   = 3'd0,
		REG_AREA_THRESHOLD = 3'd1,
		REG_ANGULAR_GAIN   = 3'd2,
		REG_LINEAR_GAIN    = 3'd3,
		REG_ANG_LIMIT      = 3'd4,
		REG_LIN_LIMIT      = 3'd5,
		REG_KEEP_MM        = 3'd6,
		REG_MODE_FLAGS     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CLASS_W-1:0] target_class;
		logic [THR_W-1:0]   area_threshold;
		logic [GAIN_W-1:0]  angular_gain;
		logic [GAIN_W-1:0]  linear_gain;
		logic [MAG_W-1:0]   ang_limit;
		logic [MAG_W-1:0]   lin_limit;
		logic [DIST_W-1:0]  keep_mm;
		logic [MODE_W-1:0]  mode_flags;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		target_class:   8'd0,
		area_threshold: 24'd20,
		angular_gain:   16'd2560,
		linear_gain:    16'd32768,
		ang_limit:      15'd1500,
		lin_limit:      15'd100,
		keep_mm:        16'd300,
		mode_flags:     2'd1
	};

	// end-of-frame selection handed to the command stages
	typedef struct packed {
		logic               valid;
		logic               found;
		logic [COORD_W-1:0] center_x;
		logic [DIST_W-1:0]  dist_mm;
	} sel_t;

	typedef struct packed {
		logic               valid;
		logic [CMD_W-1:0]   angular;
		logic [CMD_W-1:0]   linear;
		logic               found;
		logic [COORD_W-1:0] center_x;
		logic               publish;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/target_select_follow_command.sv]
// target_select_follow_command: picks the largest target-class box of a frame
// and issues one turn / speed command on the frame's last beat.
// Throughput: one beat per cycle, except while a finished command waits on a full
// output. The command reaches m_tvalid through the box differences, area multiply,
// selection, gain multiply and rounding registers, then clamp into the output register.
// Reset (arst_n low): registers to defaults, no frame open, pipeline empty.
`default_nettype none

module target_select_follow_command import tsf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// box_left, box_top, box_right, box_bottom, class_id, target_distance_mm
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// detection_valid
	input  wire logic                  s_tuser,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// angular_rate, linear_speed, target_center_x, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// target_found, publish_command
	output logic [1:0]                 m_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	sel_t  sel;
	cmd_t  cmd;
	logic  en;
	logic  out_valid_q;
	cmd_t  out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_CLASS:   cfg_q.target_class   <= cfg_data[CLASS_W-1:0];
				REG_AREA_THRESHOLD: cfg_q.area_threshold <= cfg_data[THR_W-1:0];
				REG_ANGULAR_GAIN:   cfg_q.angular_gain   <= cfg_data[GAIN_W-1:0];
				REG_LINEAR_GAIN:    cfg_q.linear_gain    <= cfg_data[GAIN_W-1:0];
				REG_ANG_LIMIT:      cfg_q.ang_limit      <= cfg_data[MAG_W-1:0];
				REG_LIN_LIMIT:      cfg_q.lin_limit      <= cfg_data[MAG_W-1:0];
				REG_KEEP_MM:        cfg_q.keep_mm        <= cfg_data[DIST_W-1:0];
				REG_MODE_FLAGS:     cfg_q.mode_flags     <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// the pipeline only holds when a finished command cannot move into a full output
	assign en       = !(out_valid_q && !m_tready && cmd.valid);
	assign s_tready = en;

	tsf_select u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.det_valid  (s_tuser),
		.box_left   (s_tdata[11:0]),
		.box_top    (s_tdata[23:12]),
		.box_right  (s_tdata[35:24]),
		.box_bottom (s_tdata[47:36]),
		.class_id   (s_tdata[55:48]),
		.dist_mm    (s_tdata[71:56]),
		.last       (s_tlast),
		.cfg        (cfg_q),
		.sel        (sel)
	);

	tsf_cmd u_cmd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.sel    (sel),
		.cfg    (cfg_q),
		.cmd    (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && cmd.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && cmd.valid) begin
			out_q <= cmd;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_q.center_x, out_q.linear, out_q.angular};
	assign m_tuser  = {out_q.publish, out_q.found};

endmodule

`default_nettype wire

[rtl/tsf_select.sv]
// tsf_select: per-beat box area and running best-target selection over a frame.
// Depends on tsf_pkg.
`default_nettype none

module tsf_select import tsf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic               det_valid,
	input  wire logic [COORD_W-1:0] box_left,
	input  wire logic [COORD_W-1:0] box_top,
	input  wire logic [COORD_W-1:0] box_right,
	input  wire logic [COORD_W-1:0] box_bottom,
	input  wire logic [CLASS_W-1:0] class_id,
	input  wire logic [DIST_W-1:0]  dist_mm,
	input  wire logic               last,
	input  wire cfg_t               cfg,
	output sel_t                    sel
);

	logic signed [COORD_W:0]   dw_c, dh_c;
	logic                      match_c;

	logic                      valid_s1, match_s1, last_s1;
	logic signed [COORD_W:0]   dw_s1, dh_s1;
	logic [COORD_W-1:0]        left_s1, right_s1;
	logic [DIST_W-1:0]         dist_s1;

	logic                      valid_s2, match_s2, last_s2;
	logic signed [AREA_W-1:0]  area_s2;
	logic [COORD_W-1:0]        left_s2, right_s2;
	logic [DIST_W-1:0]         dist_s2;

	logic signed [AREA_W-1:0]  best_area_q;
	logic [COORD_W-1:0]        best_left_q, best_right_q;
	logic                      found_q, frame_open_q;

	logic signed [AREA_W-1:0]  base_area, new_area;
	logic                      base_found, new_found, take;
	logic [COORD_W-1:0]        new_left, new_right;
	logic [COORD_W:0]          cx_sum;

	logic                      sel_valid_s3, sel_found_s3;
	logic [COORD_W-1:0]        sel_cx_s3;
	logic [DIST_W-1:0]         sel_dist_s3;

	assign dw_c    = $signed({1'b0, box_right}) - $signed({1'b0, box_left});
	assign dh_c    = $signed({1'b0, box_bottom}) - $signed({1'b0, box_top});
	assign match_c = det_valid && (class_id == cfg.target_class);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			match_s1 <= match_c;
			last_s1  <= last;
			dw_s1    <= dw_c;
			dh_s1    <= dh_c;
			left_s1  <= box_left;
			right_s1 <= box_right;
			dist_s1  <= dist_mm;

			match_s2 <= match_s1;
			last_s2  <= last_s1;
			area_s2  <= dw_s1 * dh_s1;
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			dist_s2  <= dist_s1;
		end
	end

	// a closed frame restarts from the threshold with no target
	always_comb begin
		base_area  = frame_open_q ? best_area_q : $signed({2'b0, cfg.area_threshold});
		base_found = frame_open_q && found_q;
		take       = match_s2 && (area_s2 > base_area);
		new_area   = take ? area_s2 : base_area;
		new_found  = base_found || take;
		new_left   = take ? left_s2 : best_left_q;
		new_right  = take ? right_s2 : best_right_q;
		cx_sum     = {1'b0, new_left} + {1'b0, new_right};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			frame_open_q <= 1'b0;
			sel_valid_s3 <= 1'b0;
		end else if (en) begin
			sel_valid_s3 <= valid_s2 && last_s2;
			if (valid_s2) begin
				found_q      <= new_found;
				frame_open_q <= !last_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_s2) begin
				best_area_q  <= new_area;
				best_left_q  <= new_left;
				best_right_q <= new_right;
			end
			sel_found_s3 <= new_found;
			sel_cx_s3    <= new_found ? cx_sum[COORD_W:1] : '0;
			sel_dist_s3  <= dist_s2;
		end
	end

	assign sel = {sel_valid_s3, sel_found_s3, sel_cx_s3, sel_dist_s3};

endmodule

`default_nettype wire

[rtl/tsf_cmd.sv]
// tsf_cmd: gain products, rounding and clamping of the follow command.
// Depends on tsf_pkg; fed by tsf_select.
`default_nettype none

module tsf_cmd import tsf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire sel_t sel,
	input  wire cfg_t cfg,
	output cmd_t      cmd
);

	localparam int ERR_W   = COORD_W + 2;
	localparam int DERR_W  = DIST_W + 1;
	localparam int APROD_W = GAIN_W + 1 + ERR_W;
	localparam int LPROD_W = GAIN_W + 1 + DERR_W;
	localparam int ARND_W  = APROD_W + 1 - 8;
	localparam int LRND_W  = LPROD_W + 1 - 16;
	localparam logic signed [ERR_W-1:0] HALF_WIDTH = ERR_W'(IMAGE_WIDTH / 2);

	logic signed [ERR_W-1:0]   err_c;
	logic signed [DERR_W-1:0]  derr_c;
	logic                      dist_ok;

	logic                      valid_s4, found_s4;
	logic [COORD_W-1:0]        cx_s4;
	logic signed [APROD_W-1:0] ang_prod_s4;
	logic signed [LPROD_W-1:0] lin_prod_s4;

	logic [APROD_W-1:0]        ang_abs;
	logic [LPROD_W-1:0]        lin_abs;
	logic [APROD_W:0]          ang_sum;
	logic [LPROD_W:0]          lin_sum;

	logic                      valid_s5, found_s5, ang_neg_s5, lin_neg_s5;
	logic [COORD_W-1:0]        cx_s5;
	logic [ARND_W-1:0]         ang_rnd_s5;
	logic [LRND_W-1:0]         lin_rnd_s5;

	logic [MAG_W-1:0]          ang_cl, lin_cl;
	logic [CMD_W-1:0]          ang_val, lin_val;

	assign dist_ok = (sel.dist_mm >= DIST_W'(VALID_MIN_MM)) &&
	                 (sel.dist_mm <= DIST_W'(VALID_MAX_MM));
	assign err_c   = HALF_WIDTH - $signed({2'b0, sel.center_x});
	assign derr_c  = dist_ok ? ($signed({1'b0, sel.dist_mm}) - $signed({1'b0, cfg.keep_mm}))
	                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sel.valid;
			valid_s5 <= valid_s4;
		end
	end

	// halves round away from zero: round the magnitude, restore sign later
	always_comb begin
		ang_abs = ang_prod_s4[APROD_W-1] ? APROD_W'(-ang_prod_s4) : APROD_W'(ang_prod_s4);
		lin_abs = lin_prod_s4[LPROD_W-1] ? LPROD_W'(-lin_prod_s4) : LPROD_W'(lin_prod_s4);
		ang_sum = {1'b0, ang_abs} + (APROD_W + 1)'(128);
		lin_sum = {1'b0, lin_abs} + (LPROD_W + 1)'(32768);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_s4    <= sel.found;
			cx_s4       <= sel.center_x;
			ang_prod_s4 <= $signed({1'b0, cfg.angular_gain}) * err_c;
			lin_prod_s4 <= $signed({1'b0, cfg.linear_gain}) * derr_c;

			found_s5    <= found_s4;
			cx_s5       <= cx_s4;
			ang_neg_s5  <= ang_prod_s4[APROD_W-1];
			lin_neg_s5  <= lin_prod_s4[LPROD_W-1];
			ang_rnd_s5  <= ang_sum[APROD_W:8];
			lin_rnd_s5  <= lin_sum[LPROD_W:16];
		end
	end

	always_comb begin
		ang_cl  = (ang_rnd_s5 > ARND_W'(cfg.ang_limit)) ? cfg.ang_limit
		                                                : ang_rnd_s5[MAG_W-1:0];
		lin_cl  = (lin_rnd_s5 > LRND_W'(cfg.lin_limit)) ? cfg.lin_limit
		                                                : lin_rnd_s5[MAG_W-1:0];
		ang_val = ang_neg_s5 ? CMD_W'(-{1'b0, ang_cl}) : {1'b0, ang_cl};
		lin_val = lin_neg_s5 ? CMD_W'(-{1'b0, lin_cl}) : {1'b0, lin_cl};

		cmd.valid    = valid_s5;
		cmd.found    = found_s5;
		cmd.center_x = cx_s5;
		cmd.angular  = found_s5 ? ang_val : '0;
		cmd.linear   = (found_s5 && cfg.mode_flags[0]) ? lin_val : '0;
		cmd.publish  = cfg.mode_flags[1];
	end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// tb: self-checking bench for target_select_follow_command, with a clocked driver,
// a clocked monitor and a built-in model of the follow command computation.
// Depends on tsf_pkg and the target_select_follow_command RTL.
`default_nettype none

module tb;
	import tsf_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD   = 300;

	typedef struct {
		logic               det_valid;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic [CLASS_W-1:0] class_id;
		logic [DIST_W-1:0]  dist_mm;
		logic               last;
	} det_beat_t;

	typedef struct {
		logic signed [CMD_W-1:0] angular;
		logic signed [CMD_W-1:0] linear;
		logic                    found;
		logic [COORD_W-1:0]      center_x;
		logic                    publish;
	} follow_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_index = REG_TARGET_CLASS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	target_select_follow_command dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// model copy of registers and frame state
	cfg_t        follow_cfg = CFG_RESET;
	longint      best_area = 0;
	logic [COORD_W-1:0] best_left = '0;
	logic [COORD_W-1:0] best_right = '0;
	logic        found_flag = 1'b0;
	logic        frame_open = 1'b0;

	det_beat_t   pending_beats[$];
	follow_cmd_t cmd_expected[$];
	det_beat_t   beat_on_bus;

	logic src_idle_on = 1'b0;
	logic sink_idle_on = 1'b0;
	int   src_gap = 0;
	int   sink_gap = 0;
	int   hold_req = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   mismatches = 0;
	int   beats_sent = 0;
	int   cmds_checked = 0;
	int   cmds_found = 0;
	int   settings_used = 0;
	int   quiet_cycles = 0;

	function automatic longint round_half_away(longint p, int sh);
		longint half;
		half = longint'(1) <<< (sh - 1);
		if (p >= 0)
			return (p + half) >>> sh;
		return -((-p + half) >>> sh);
	endfunction

	function automatic longint clamp_to(longint v, longint mag);
		if (v > mag)
			return mag;
		if (v < -mag)
			return -mag;
		return v;
	endfunction

	// frame selection and command computation for one accepted beat
	task automatic follow_step(det_beat_t d);
		longint lft, rgt, tp, btm, area, err, turn, speed, rng, keep;
		logic [COORD_W:0] cx_sum;
		follow_cmd_t c;
		if (!frame_open) begin
			best_area = longint'(follow_cfg.area_threshold);
			found_flag = 1'b0;
			frame_open = 1'b1;
		end
		if (d.det_valid && d.class_id == follow_cfg.target_class) begin
			lft = longint'(d.left);
			rgt = longint'(d.right);
			tp = longint'(d.top);
			btm = longint'(d.bottom);
			area = (rgt - lft) * (btm - tp);
			if (area > best_area) begin
				best_area = area;
				best_left = d.left;
				best_right = d.right;
				found_flag = 1'b1;
			end
		end
		if (d.last) begin
			frame_open = 1'b0;
			turn = 0;
			speed = 0;
			c.center_x = '0;
			if (found_flag) begin
				cx_sum = {1'b0, best_left} + {1'b0, best_right};
				c.center_x = cx_sum[COORD_W:1];
				err = longint'(IMAGE_WIDTH / 2) - longint'(c.center_x);
				turn = clamp_to(round_half_away(longint'(follow_cfg.angular_gain) * err, 8),
					longint'(follow_cfg.ang_limit));
				rng = longint'(d.dist_mm);
				keep = longint'(follow_cfg.keep_mm);
				if (rng >= longint'(VALID_MIN_MM) && rng <= longint'(VALID_MAX_MM))
					speed = round_half_away(longint'(follow_cfg.linear_gain) * (rng - keep), 16);
				speed = clamp_to(speed, longint'(follow_cfg.lin_limit));
				if (!follow_cfg.mode_flags[0])
					speed = 0;
			end
			c.angular = turn[CMD_W-1:0];
			c.linear = speed[CMD_W-1:0];
			c.found = found_flag;
			c.publish = follow_cfg.mode_flags[1];
			cmd_expected.insert(cmd_expected.size(), c);
		end
	endtask

	// driver: one beat per handshake, random source gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				follow_step(beat_on_bus);
				beats_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					beat_on_bus = pending_beats.pop_front();
					s_tdata <= {beat_on_bus.dist_mm, beat_on_bus.class_id, beat_on_bus.bottom,
						beat_on_bus.right, beat_on_bus.top, beat_on_bus.left};
					s_tuser <= beat_on_bus.det_valid;
					s_tlast <= beat_on_bus.last;
					s_tvalid <= 1'b1;
					if (src_idle_on && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 7);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// monitor: compare each command beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		follow_cmd_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (cmd_expected.size() == 0) begin
					$display("%0t: unexpected command beat expected none got tdata %h tuser %b",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = cmd_expected.pop_front();
					check_field("angular_rate", int'(want.angular), int'($signed(m_tdata[15:0])));
					check_field("linear_speed", int'(want.linear), int'($signed(m_tdata[31:16])));
					check_field("target_center_x", int'(want.center_x), int'(m_tdata[43:32]));
					check_field("target_found", int'(want.found), int'(m_tuser[0]));
					check_field("publish_command", int'(want.publish), int'(m_tuser[1]));
					cmds_checked++;
					if (want.found)
						cmds_found++;
				end
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (sink_idle_on && $urandom_range(0, 9) == 0)
					sink_gap = $urandom_range(1, 7);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d commands outstanding",
					$time, quiet_cycles, cmd_expected.size());
				$display("** target_select_follow_command: FAILED **");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		REG_TARGET_CLASS:   follow_cfg.target_class = val[CLASS_W-1:0];
		REG_AREA_THRESHOLD: follow_cfg.area_threshold = val[THR_W-1:0];
		REG_ANGULAR_GAIN:   follow_cfg.angular_gain = val[GAIN_W-1:0];
		REG_LINEAR_GAIN:    follow_cfg.linear_gain = val[GAIN_W-1:0];
		REG_ANG_LIMIT:      follow_cfg.ang_limit = val[MAG_W-1:0];
		REG_LIN_LIMIT:      follow_cfg.lin_limit = val[MAG_W-1:0];
		REG_KEEP_MM:        follow_cfg.keep_mm = val[DIST_W-1:0];
		REG_MODE_FLAGS:     follow_cfg.mode_flags = val[MODE_W-1:0];
		default: ;
		endcase
	endtask

	task automatic load_setting(cfg_t c);
		write_reg(REG_TARGET_CLASS, CFG_DATA_W'(c.target_class));
		write_reg(REG_AREA_THRESHOLD, c.area_threshold);
		write_reg(REG_ANGULAR_GAIN, CFG_DATA_W'(c.angular_gain));
		write_reg(REG_LINEAR_GAIN, CFG_DATA_W'(c.linear_gain));
		write_reg(REG_ANG_LIMIT, CFG_DATA_W'(c.ang_limit));
		write_reg(REG_LIN_LIMIT, CFG_DATA_W'(c.lin_limit));
		write_reg(REG_KEEP_MM, CFG_DATA_W'(c.keep_mm));
		write_reg(REG_MODE_FLAGS, CFG_DATA_W'(c.mode_flags));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic cfg_t rand_setting();
		cfg_t c;
		c.target_class = CLASS_W'($urandom_range(0, 255));
		case ($urandom_range(0, 5))
		0: c.area_threshold = '0;
		1: c.area_threshold = THR_W'($urandom_range(0, 16777215));
		default: c.area_threshold = THR_W'($urandom_range(0, 400));
		endcase
		c.angular_gain = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
			: $urandom_range(0, 4096));
		c.linear_gain = GAIN_W'($urandom_range(0, 65535));
		c.ang_limit = MAG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
			: $urandom_range(0, 3000));
		c.lin_limit = MAG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
			: $urandom_range(0, 1000));
		c.keep_mm = DIST_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
			: $urandom_range(0, 6000));
		c.mode_flags = MODE_W'($urandom_range(0, 3));
		return c;
	endfunction

	task automatic push_beat(int v, int l, int t, int r, int b, int cls, int rng, int last);
		det_beat_t d;
		d.det_valid = 1'(v);
		d.left = COORD_W'(l);
		d.top = COORD_W'(t);
		d.right = COORD_W'(r);
		d.bottom = COORD_W'(b);
		d.class_id = CLASS_W'(cls);
		d.dist_mm = DIST_W'(rng);
		d.last = 1'(last);
		pending_beats.insert(pending_beats.size(), d);
	endtask

	function automatic int rand_coord_pair_end(int start);
		int w;
		w = $urandom_range(0, 3) != 0 ? $urandom_range(0, 64) : $urandom_range(0, 4095);
		return (start + w > 4095) ? 4095 : start + w;
	endfunction

	function automatic det_beat_t rand_box(logic last);
		det_beat_t d;
		int pick;
		d.det_valid = $urandom_range(0, 9) != 0;
		d.class_id = ($urandom_range(0, 9) < 6) ? follow_cfg.target_class
			: CLASS_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			d.left = COORD_W'($urandom_range(0, 4095));
			d.right = COORD_W'(rand_coord_pair_end(int'(d.left)));
			d.top = COORD_W'($urandom_range(0, 4095));
			d.bottom = COORD_W'(rand_coord_pair_end(int'(d.top)));
		end else if (pick < 17) begin
			d.left = COORD_W'($urandom_range(0, 4095));
			d.right = COORD_W'($urandom_range(0, 4095));
			d.top = COORD_W'($urandom_range(0, 4095));
			d.bottom = COORD_W'($urandom_range(0, 4095));
		end else begin
			d.left = $urandom_range(0, 1) ? '1 : '0;
			d.right = $urandom_range(0, 1) ? '1 : '0;
			d.top = $urandom_range(0, 1) ? '1 : '0;
			d.bottom = $urandom_range(0, 1) ? '1 : '0;
		end
		pick = $urandom_range(0, 19);
		if (pick < 14)
			d.dist_mm = DIST_W'($urandom_range(0, 5100));
		else if (pick < 17)
			d.dist_mm = DIST_W'($urandom_range(0, 65535));
		else
			case ($urandom_range(0, 5))
			0: d.dist_mm = DIST_W'(VALID_MIN_MM - 1);
			1: d.dist_mm = DIST_W'(VALID_MIN_MM);
			2: d.dist_mm = DIST_W'(VALID_MAX_MM);
			3: d.dist_mm = DIST_W'(VALID_MAX_MM + 1);
			4: d.dist_mm = '0;
			default: d.dist_mm = 16'hffff;
			endcase
		d.last = last;
		return d;
	endfunction

	// whole frames only, so a phase always ends on a frame boundary
	task automatic queue_frames(int n_beats, int max_boxes);
		int queued, nbox;
		queued = 0;
		while (queued < n_beats) begin
			nbox = $urandom_range(1, max_boxes);
			for (int i = 0; i < nbox; i++)
				pending_beats.insert(pending_beats.size(), rand_box(i == nbox - 1));
			queued += nbox;
		end
	endtask

	task automatic wait_drained();
		while (pending_beats.size() > 0 || s_tvalid || cmd_expected.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		cfg_t c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: threshold edge, ties, class filter, corners, distance window
		push_beat(0, 0, 0, 0, 0, 0, 0, 1);
		push_beat(1, 10, 10, 14, 15, 0, 400, 1);
		push_beat(1, 100, 100, 103, 107, 0, 400, 1);
		push_beat(1, 0, 0, 10, 10, 0, 0, 0);
		push_beat(1, 600, 0, 610, 10, 0, 0, 0);
		push_beat(1, 300, 300, 302, 302, 5, 0, 0);
		push_beat(0, 0, 0, 4095, 4095, 0, 0, 0);
		push_beat(1, 0, 0, 0, 0, 0, 49, 1);
		push_beat(1, 200, 0, 210, 10, 0, 0, 0);
		push_beat(1, 330, 0, 350, 20, 0, 50, 1);
		push_beat(1, 400, 400, 300, 300, 0, 5000, 1);
		push_beat(1, 500, 0, 400, 100, 0, 5001, 1);
		push_beat(1, 0, 0, 4095, 4095, 0, 65535, 1);
		push_beat(1, 4095, 4095, 0, 0, 255, 65535, 0);
		push_beat(0, 4095, 4095, 4095, 4095, 255, 65535, 1);
		wait_drained();

		// widest gains and clamps
		c = '{target_class: 8'hff, area_threshold: 24'd0, angular_gain: 16'hffff,
			linear_gain: 16'hffff, ang_limit: 15'h7fff, lin_limit: 15'h7fff,
			keep_mm: 16'd0, mode_flags: 2'd3};
		load_setting(c);
		push_beat(1, 0, 0, 4095, 4095, 255, 5000, 1);
		push_beat(1, 4095, 4095, 4094, 4094, 255, 50, 1);
		push_beat(1, 0, 0, 0, 0, 255, 1000, 1);
		queue_frames(20, 4);
		wait_drained();

		// nothing can pass the threshold, zero gains and clamps
		c = '{target_class: 8'd0, area_threshold: 24'hffffff, angular_gain: 16'd0,
			linear_gain: 16'd0, ang_limit: 15'd0, lin_limit: 15'd0,
			keep_mm: 16'hffff, mode_flags: 2'd0};
		load_setting(c);
		push_beat(1, 0, 0, 4095, 4095, 0, 2000, 1);
		queue_frames(20, 4);
		wait_drained();

		// rounding of halves away from zero
		c = '{target_class: 8'd7, area_threshold: 24'd0, angular_gain: 16'd1,
			linear_gain: 16'd32768, ang_limit: 15'h7fff, lin_limit: 15'h7fff,
			keep_mm: 16'd0, mode_flags: 2'd2};
		load_setting(c);
		push_beat(1, 190, 0, 194, 10, 7, 51, 1);
		push_beat(1, 446, 0, 450, 10, 7, 51, 1);
		wait_drained();
		write_reg(REG_MODE_FLAGS, CFG_DATA_W'(3));
		write_reg(REG_KEEP_MM, CFG_DATA_W'(5000));
		@(posedge clk);
		cfg_we <= 1'b0;
		push_beat(1, 190, 0, 194, 10, 7, 4999, 1);
		push_beat(1, 190, 0, 194, 10, 7, 51, 1);
		wait_drained();

		// long receiver hold while the source keeps streaming short frames
		c = rand_setting();
		c.area_threshold = '0;
		load_setting(c);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_req++;
		queue_frames(100, 2);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			load_setting(rand_setting());
			src_idle_on = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			queue_frames(65, 8);
			wait_drained();
		end

		// closing stretch with no idling at all
		load_setting(rand_setting());
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		queue_frames(60, 6);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("covered %0d beats, %0d follow commands (%0d with a target) over %0d settings",
			beats_sent, cmds_checked, cmds_found, settings_used + 1);
		if (mismatches == 0) begin
			$display("** target_select_follow_command: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** target_select_follow_command: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/tsf_pkg.sv
rtl/tsf_select.sv
rtl/tsf_cmd.sv
rtl/target_select_follow_command.sv
tb/sv/tb.sv
